FILE: hdl/spq_pkg.sv
// shared types and constants for the sorted priority queue
`default_nettype none

package spq_pkg;

	localparam int DEPTH          = 16;
	localparam int DATA_WIDTH     = 32;
	localparam int PRIORITY_WIDTH = 8;
	localparam int COUNT_WIDTH    = $clog2(DEPTH + 1);
	localparam int INDEX_WIDTH    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_PEEK    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       operation;
		logic [DATA_WIDTH-1:0]     item_value;
		logic [PRIORITY_WIDTH-1:0] item_priority;
	} request_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0]     head_value;
		logic [PRIORITY_WIDTH-1:0] head_priority;
		logic [COUNT_WIDTH-1:0]    entry_count;
		status_t                   status;
		logic                      is_empty;
		logic                      is_full;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/spq_datapath.sv
// slot registers, sorted insert and shift logic, result register
`default_nettype none

module spq_datapath (
	input  wire                clk,
	input  wire                arst_n,
	input  spq_pkg::dp_cmd_t   cmd,
	input  spq_pkg::request_t  request,
	output spq_pkg::result_t   result
);
	import spq_pkg::*;

	logic [DATA_WIDTH-1:0]     val_q [DEPTH];
	logic [PRIORITY_WIDTH-1:0] pri_q [DEPTH];
	logic [COUNT_WIDTH-1:0]    count_q;
	request_t                  req_q;
	result_t                   result_q;

	logic [DEPTH-1:0]          le;
	logic                      empty;
	logic                      full;
	logic                      do_enq;
	logic                      do_deq;
	logic [COUNT_WIDTH-1:0]    count_next;
	result_t                   result_next;

	assign empty  = (count_q == '0);
	assign full   = (count_q == COUNT_WIDTH'(DEPTH));
	assign do_enq = (req_q.operation == OP_ENQUEUE) && !full;
	assign do_deq = (req_q.operation == OP_DEQUEUE) && !empty;

	// per-slot compare: stored entry stays ahead of the new one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			le[i] = (COUNT_WIDTH'(i) < count_q) && (pri_q[i] <= req_q.item_priority);
		end
	end

	// next count, head and status
	always_comb begin
		count_next  = count_q;
		result_next = '0;
		result_next.status = ST_OK;
		case (req_q.operation)
			OP_ENQUEUE: begin
				if (full) begin
					result_next.status        = ST_OVERFLOW;
					result_next.head_value    = val_q[0];
					result_next.head_priority = pri_q[0];
				end else begin
					count_next = count_q + 1'b1;
					if (le[0]) begin
						result_next.head_value    = val_q[0];
						result_next.head_priority = pri_q[0];
					end else begin
						result_next.head_value    = req_q.item_value;
						result_next.head_priority = req_q.item_priority;
					end
				end
			end
			OP_DEQUEUE: begin
				if (empty) begin
					result_next.status = ST_UNDERFLOW;
				end else begin
					count_next                = count_q - 1'b1;
					result_next.head_value    = val_q[0];
					result_next.head_priority = pri_q[0];
				end
			end
			OP_PEEK: begin
				if (empty) begin
					result_next.status = ST_UNDERFLOW;
				end else begin
					result_next.head_value    = val_q[0];
					result_next.head_priority = pri_q[0];
				end
			end
			default: begin
				count_next = '0;
			end
		endcase
		result_next.entry_count = count_next;
		result_next.is_empty    = (count_next == '0);
		result_next.is_full     = (count_next == COUNT_WIDTH'(DEPTH));
	end

	// latch the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
	end

	// slot shift register: insert at first slot past the prefix, or shift down
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (do_enq && !le[i]) begin
					if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
						val_q[i] <= req_q.item_value;
						pri_q[i] <= req_q.item_priority;
					end else begin
						val_q[i] <= val_q[(i == 0) ? 0 : i - 1];
						pri_q[i] <= pri_q[(i == 0) ? 0 : i - 1];
					end
				end else if (do_deq && i < DEPTH - 1) begin
					val_q[i] <= val_q[(i < DEPTH - 1) ? i + 1 : i];
					pri_q[i] <= pri_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	// count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_next;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			result_q <= result_next;
		end
	end

	assign result = result_q;

endmodule

`default_nettype wire

FILE: hdl/spq_controller.sv
// request sequencer: accept, execute, report
`default_nettype none

module spq_controller (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	output logic              done,
	output spq_pkg::dp_cmd_t  cmd
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPORT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// state and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_REPORT;
					done_q  <= 1'b1;
				end
				S_REPORT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b0;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	// datapath commands
	assign cmd.load = start && !busy_q;
	assign cmd.exec = (state_q == S_EXEC);
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

`default_nettype wire

FILE: hdl/sorted_priority_queue.sv
// top level of the sorted priority queue
//
//   channel   handshake        payload
//   request   start / busy     request (request_t)
//   result    done strobe      result (result_t)
//
// each request passes through accept, an execute state in which all 16 slots
// compare and shift together, and the report state in which done shows the result.
// busy stays high from acceptance through the done cycle.
// reset clears the entry count and the controller; slot contents are not cleared.
// done is high for exactly one cycle; the receiver cannot stall it.
`default_nettype none

module sorted_priority_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  spq_pkg::request_t  request,
	output logic               done,
	output spq_pkg::result_t   result
);
	import spq_pkg::*;

	dp_cmd_t cmd;

	spq_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	spq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.request (request),
		.result  (result)
	);

	// an accepted request raises busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted request");

	// the strobe lasts one cycle and only inside a busy window
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (busy && !$past(done)))
		else $error("done strobe outside busy window or repeated");

	// empty flag agrees with count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.is_empty == (result.entry_count == '0)))
		else $error("empty flag disagrees with entry count");

	// count never exceeds depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.entry_count <= COUNT_WIDTH'(DEPTH)))
		else $error("entry count above depth");

endmodule

`default_nettype wire

FILE: tb/sorted_priority_queue_tb.sv
// testbench for the sorted priority queue: directed rows, then random requests checked on the fly
module sorted_priority_queue_tb;

	import spq_pkg::*;

	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 11;
	localparam int RANDOM_REQUESTS = 1850;
	localparam int PHASE_COUNT     = 4;
	localparam int MODE_RUN        = 32;
	localparam int SETTLE_CYCLES   = 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int REPORT_LIMIT    = 10;

	typedef struct packed {
		request_t req;
		logic     typed;
		result_t  want;
	} directed_row_t;

	logic     clk     = 1'b0;
	logic     arst_n  = 1'b0;
	logic     start   = 1'b0;
	request_t request = '0;
	logic     busy;
	logic     done;
	result_t  result;

	// shadow copy of the sorted store
	logic [DATA_WIDTH-1:0]     shadow_values [DEPTH];
	logic [PRIORITY_WIDTH-1:0] shadow_priorities [DEPTH];
	int unsigned               shadow_count = 0;

	result_t       awaited_results [$];
	directed_row_t directed_rows [$];
	int            mismatch_count = 0;
	int            cycle_count    = 0;

	sorted_priority_queue DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("sorted_priority_queue_tb: FAIL");
			$finish;
		end
	end

	// apply one request to the shadow store and return the result it should give
	function automatic result_t next_queue_result(request_t req);
		result_t res;
		int unsigned pos;
		int unsigned i;
		logic head_taken;
		res        = '0;
		res.status = ST_OK;
		head_taken = 1'b0;
		pos        = 0;
		case (req.operation)
			OP_ENQUEUE: begin
				if (shadow_count >= DEPTH) begin
					res.status = ST_OVERFLOW;
				end else begin
					// equal priorities keep arrival order
					while (pos < shadow_count && shadow_priorities[pos] <= req.item_priority)
						pos++;
					for (i = shadow_count; i > pos; i--) begin
						shadow_values[i]     = shadow_values[i-1];
						shadow_priorities[i] = shadow_priorities[i-1];
					end
					shadow_values[pos]     = req.item_value;
					shadow_priorities[pos] = req.item_priority;
					shadow_count++;
				end
			end
			OP_DEQUEUE: begin
				head_taken = 1'b1;
				if (shadow_count == 0) begin
					res.status = ST_UNDERFLOW;
				end else begin
					res.head_value    = shadow_values[0];
					res.head_priority = shadow_priorities[0];
					for (i = 1; i < shadow_count; i++) begin
						shadow_values[i-1]     = shadow_values[i];
						shadow_priorities[i-1] = shadow_priorities[i];
					end
					shadow_count--;
				end
			end
			OP_PEEK: begin
				if (shadow_count == 0)
					res.status = ST_UNDERFLOW;
			end
			default: begin
				shadow_count = 0;
			end
		endcase
		// report the head left behind unless a dequeue already filled it
		if (!head_taken && shadow_count > 0) begin
			res.head_value    = shadow_values[0];
			res.head_priority = shadow_priorities[0];
		end
		res.entry_count = COUNT_WIDTH'(shadow_count);
		res.is_empty    = (shadow_count == 0);
		res.is_full     = (shadow_count >= DEPTH);
		return res;
	endfunction

	function automatic request_t make_request(op_t op, logic [DATA_WIDTH-1:0] value,
			logic [PRIORITY_WIDTH-1:0] prio);
		request_t req;
		req.operation     = op;
		req.item_value    = value;
		req.item_priority = prio;
		return req;
	endfunction

	function automatic result_t make_result(logic [DATA_WIDTH-1:0] value,
			logic [PRIORITY_WIDTH-1:0] prio, int unsigned count, status_t st);
		result_t res;
		res.head_value    = value;
		res.head_priority = prio;
		res.entry_count   = COUNT_WIDTH'(count);
		res.status        = st;
		res.is_empty      = (count == 0);
		res.is_full       = (count >= DEPTH);
		return res;
	endfunction

	task automatic add_row(op_t op, logic [DATA_WIDTH-1:0] value,
			logic [PRIORITY_WIDTH-1:0] prio, logic typed, result_t want);
		directed_row_t row;
		row.req   = make_request(op, value, prio);
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// random sender gap, then hold start until the request is taken
	task automatic send_request(request_t req, logic typed, result_t want, int idle_pct);
		result_t predicted;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		start   <= 1'b1;
		request <= req;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = next_queue_result(req);
		awaited_results.push_back(typed ? want : predicted);
	endtask

	// pick an operation, leaning toward filling or draining the store
	function automatic op_t pick_operation(logic filling);
		int unsigned roll;
		roll = $urandom_range(99);
		if (filling) begin
			if (roll < 70) return OP_ENQUEUE;
			if (roll < 85) return OP_DEQUEUE;
			if (roll < 97) return OP_PEEK;
			return OP_CLEAR;
		end
		if (roll < 25) return OP_ENQUEUE;
		if (roll < 80) return OP_DEQUEUE;
		if (roll < 95) return OP_PEEK;
		return OP_CLEAR;
	endfunction

	// result checker
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: value %h prio %h count %0d status %0d",
						result.head_value, result.head_priority, result.entry_count,
						result.status);
			end else begin
				want = awaited_results.pop_front();
				if (result.head_value !== want.head_value ||
						result.head_priority !== want.head_priority ||
						result.entry_count !== want.entry_count ||
						result.status !== want.status ||
						result.is_empty !== want.is_empty ||
						result.is_full !== want.is_full) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display({"mismatch: expected value %h prio %h count %0d status %0d ",
							"empty %b full %b, got value %h prio %h count %0d status %0d ",
							"empty %b full %b"},
							want.head_value, want.head_priority, want.entry_count,
							want.status, want.is_empty, want.is_full,
							result.head_value, result.head_priority, result.entry_count,
							result.status, result.is_empty, result.is_full);
				end
			end
		end
	end

	// stimulus
	initial begin
		int idle_pct [PHASE_COUNT];
		int per_phase;
		int n;
		request_t req;

		idle_pct = '{0, 88, 0, 20};

		// empty store, arrival order on ties, fill to full, overflow, clear
		add_row(OP_PEEK, '0, '0, 1'b1, make_result('0, '0, 0, ST_UNDERFLOW));
		add_row(OP_DEQUEUE, '0, '0, 1'b1, make_result('0, '0, 0, ST_UNDERFLOW));
		add_row(OP_CLEAR, '0, '0, 1'b1, make_result('0, '0, 0, ST_OK));
		add_row(OP_ENQUEUE, '1, '1, 1'b1, make_result('1, '1, 1, ST_OK));
		add_row(OP_ENQUEUE, '0, '0, 1'b1, make_result('0, '0, 2, ST_OK));
		add_row(OP_ENQUEUE, 32'd1, '0, 1'b1, make_result('0, '0, 3, ST_OK));
		add_row(OP_DEQUEUE, '0, '0, 1'b1, make_result('0, '0, 2, ST_OK));
		add_row(OP_DEQUEUE, '0, '0, 1'b1, make_result(32'd1, '0, 1, ST_OK));
		for (n = 0; n < DEPTH - 1; n++)
			add_row(OP_ENQUEUE, (n % 2) ? 32'h5555_5500 | n : 32'hAAAA_AA00 | n,
				PRIORITY_WIDTH'((n % 4) * 85), 1'b0, '0);
		add_row(OP_ENQUEUE, 32'h1234_5678, 8'h40, 1'b0, '0);
		add_row(OP_CLEAR, '0, '0, 1'b1, make_result('0, '0, 0, ST_OK));
		add_row(OP_DEQUEUE, '0, '0, 1'b1, make_result('0, '0, 0, ST_UNDERFLOW));

		// reset
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].req, directed_rows[i].typed,
				directed_rows[i].want, 0);

		// random phases, each drained before the next
		per_phase = RANDOM_REQUESTS / PHASE_COUNT;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			start <= 1'b0;
			while (awaited_results.size() != 0)
				@(posedge clk);
			for (n = 0; n < per_phase; n++) begin
				req.operation     = pick_operation(((n / MODE_RUN) % 2) == 0);
				req.item_value    = $urandom;
				req.item_priority = ($urandom_range(1) != 0) ?
					PRIORITY_WIDTH'($urandom_range(3)) :
					PRIORITY_WIDTH'($urandom_range(255));
				send_request(req, 1'b0, '0, idle_pct[p]);
			end
		end
		start <= 1'b0;

		// drain and settle
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("sorted_priority_queue_tb: PASS");
		end else begin
			$display("sorted_priority_queue_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/spq_pkg.sv
hdl/spq_datapath.sv
hdl/spq_controller.sv
hdl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
